// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the timer bank RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while in reset.
`define MCTB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("timer bank assertion failed");

// Same-cycle implication: when cond holds, expr must hold.
`define MCTB_ASSERT_IMPL(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("timer bank assertion failed");

// Next-cycle implication: when cond holds, expr must hold in the cycle after.
`define MCTB_ASSERT_NEXT(lbl, clk, rst, cond, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("timer bank assertion failed");

`endif

// ----- design/mctb_pkg.sv -----
// ---------------------------------------------------------------------------
// mctb_pkg
// Types and constants shared by the timer bank modules and channels.
// ---------------------------------------------------------------------------
package mctb_pkg;

   // Field widths
   localparam int ACTION_W = 3;
   localparam int CHAN_W   = 3;
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 2;

   // Largest bank the 3-bit channel fields can address
   localparam int BANK_MAX = 8;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CREATE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_START  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_REPLY     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXPIRE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;

   // Reply status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;   // capture the accepted request
      logic decode;  // apply command or advance time base
      logic scan;    // check one channel for expiry
      logic emit;    // load one result into the output register
   } mctb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_tick;
      logic is_known;
      logic scan_end;
      logic slot_free;
      logic emit_last;
   } mctb_sts_type;

endpackage

// ----- design/mctb_chan_if.sv -----
// ---------------------------------------------------------------------------
// mctb_chan_if
// Valid/ready request and result channels of the timer bank.
// ---------------------------------------------------------------------------
interface mctb_req_if
   import mctb_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CHAN_W-1:0]   channel;
   logic [TIME_W-1:0]   interval;
   logic                repeat_req;

   modport source (output valid, output action, output channel, output interval,
                   output repeat_req, input ready);
   modport sink   (input valid, input action, input channel, input interval,
                   input repeat_req, output ready);
endinterface

interface mctb_rsp_if
   import mctb_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] event_kind;
   logic              status;
   logic [CHAN_W-1:0] channel_out;
   logic              last;

   modport source (output valid, output event_kind, output status, output channel_out,
                   output last, input ready);
   modport sink   (input valid, input event_kind, input status, input channel_out,
                   input last, output ready);
endinterface

// ----- design/mctb_ctrl.sv -----
// ---------------------------------------------------------------------------
// mctb_ctrl
// Sequencer: accept, decode, per-channel expiry scan, result emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mctb_ctrl
   import mctb_pkg::*;
   (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mctb_sts_type sts,
   output mctb_cmd_type cmd
   );

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (!sts.is_known) begin
               state_in = S_IDLE;
            end else if (sts.is_tick) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            cmd.emit = sts.slot_free;
            if (sts.slot_free && sts.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // An accepted request is always decoded next
   `MCTB_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == S_DECODE)
   // Emission only ends once the final result is loaded
   `MCTB_ASSERT_NEXT(a_emit_hold, clock, reset, (state_ff == S_EMIT) && !(sts.slot_free && sts.emit_last), state_ff == S_EMIT)

endmodule

// ----- design/mctb_dpath.sv -----
// ---------------------------------------------------------------------------
// mctb_dpath
// Channel store, time base, expiry compare unit and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mctb_dpath
   import mctb_pkg::*;
   #(
   parameter int CHANNEL_COUNT = 8
   )
   (
   input  logic                clock,
   input  logic                reset,
   input  mctb_cmd_type        cmd,
   output mctb_sts_type        sts,
   // request payload
   input  logic [ACTION_W-1:0] req_action,
   input  logic [CHAN_W-1:0]   req_channel,
   input  logic [TIME_W-1:0]   req_interval,
   input  logic                req_repeat_req,
   // result register
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_event_kind,
   output logic                rsp_status,
   output logic [CHAN_W-1:0]   rsp_channel_out,
   output logic                rsp_last
   );

   localparam int BANK  = (CHANNEL_COUNT < BANK_MAX) ? CHANNEL_COUNT : BANK_MAX;
   localparam int IDX_W = (BANK > 1) ? $clog2(BANK) : 1;

   // Latched request
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [CHAN_W-1:0]   ch_ff, ch_in;
   logic [TIME_W-1:0]   ivl_ff, ivl_in;
   logic                rep_ff, rep_in;

   // Timer state
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [BANK-1:0]     alloc_ff, alloc_in;
   logic [BANK-1:0]     run_ff, run_in;
   logic [BANK-1:0]     per_ff, per_in;
   logic [TIME_W-1:0]   stamp_ff [BANK];
   logic [TIME_W-1:0]   stamp_in [BANK];
   logic [TIME_W-1:0]   tgt_ff [BANK];
   logic [TIME_W-1:0]   tgt_in [BANK];

   // Scan and reply state
   logic [BANK-1:0]     mask_ff, mask_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                rsts_ff, rsts_in;
   logic [CHAN_W-1:0]   rchan_ff, rchan_in;

   // Output register
   logic                ovalid_ff, ovalid_in;
   logic [KIND_W-1:0]   okind_ff, okind_in;
   logic                ostat_ff, ostat_in;
   logic [CHAN_W-1:0]   ochan_ff, ochan_in;
   logic                olast_ff, olast_in;

   // Decode helpers
   logic                ch_ok;
   logic [IDX_W-1:0]    ch_idx;
   logic                free_found;
   logic [IDX_W-1:0]    free_idx;
   logic [IDX_W-1:0]    low_idx;
   logic [BANK-1:0]     mask_rest;
   logic [TIME_W-1:0]   elapsed;
   logic                hit;
   logic                is_tick;
   logic                slot_free;

   assign ch_ok     = {1'b0, ch_ff} < (CHAN_W+1)'(BANK);
   assign ch_idx    = ch_ff[IDX_W-1:0];
   assign is_tick   = act_ff == ACT_TICK;
   assign slot_free = !ovalid_ff || rsp_ready;
   assign mask_rest = mask_ff & (mask_ff - 1'b1);

   // Lowest free channel for create
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = BANK - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Lowest pending expiry
   always_comb begin
      low_idx = '0;
      for (int i = BANK - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   // Expiry compare for the channel under scan (wraps modulo 2^32)
   assign elapsed = time_ff - stamp_ff[idx_ff];
   assign hit     = run_ff[idx_ff] && (elapsed >= tgt_ff[idx_ff]);

   // Status to controller
   always_comb begin
      sts           = '0;
      sts.is_tick   = is_tick;
      sts.is_known  = act_ff <= ACT_STOP;
      sts.scan_end  = idx_ff == IDX_W'(BANK - 1);
      sts.slot_free = slot_free;
      sts.emit_last = !is_tick || (mask_rest == '0);
   end

   // Next-state logic
   always_comb begin
      act_in    = act_ff;
      ch_in     = ch_ff;
      ivl_in    = ivl_ff;
      rep_in    = rep_ff;
      time_in   = time_ff;
      alloc_in  = alloc_ff;
      run_in    = run_ff;
      per_in    = per_ff;
      stamp_in  = stamp_ff;
      tgt_in    = tgt_ff;
      mask_in   = mask_ff;
      idx_in    = idx_ff;
      rsts_in   = rsts_ff;
      rchan_in  = rchan_ff;
      ovalid_in = ovalid_ff;
      okind_in  = okind_ff;
      ostat_in  = ostat_ff;
      ochan_in  = ochan_ff;
      olast_in  = olast_ff;

      // capture request
      if (cmd.latch) begin
         act_in = req_action;
         ch_in  = req_channel;
         ivl_in = req_interval;
         rep_in = req_repeat_req;
      end

      // apply command or start a tick
      if (cmd.decode) begin
         rsts_in  = STATUS_OK;
         rchan_in = '0;
         case (act_ff)
            ACT_TICK: begin
               time_in = time_ff + 1'b1;
               mask_in = '0;
               idx_in  = '0;
            end
            ACT_CREATE: begin
               if (free_found) begin
                  alloc_in[free_idx] = 1'b1;
                  run_in[free_idx]   = 1'b0;
                  per_in[free_idx]   = 1'b0;
                  rchan_in           = CHAN_W'(free_idx);
               end else begin
                  rsts_in = STATUS_FULL;
               end
            end
            ACT_DELETE: begin
               // stamp and target only matter once start rewrites them
               if (ch_ok) begin
                  alloc_in[ch_idx] = 1'b0;
                  run_in[ch_idx]   = 1'b0;
                  per_in[ch_idx]   = 1'b0;
               end
            end
            ACT_START: begin
               if (ch_ok) begin
                  stamp_in[ch_idx] = time_ff;
                  tgt_in[ch_idx]   = ivl_ff;
                  run_in[ch_idx]   = 1'b1;
                  per_in[ch_idx]   = rep_ff;
               end
            end
            ACT_STOP: begin
               if (ch_ok) begin
                  run_in[ch_idx] = 1'b0;
                  per_in[ch_idx] = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // one channel per cycle: restart or stop, flag allocated ones
      if (cmd.scan) begin
         if (hit) begin
            if (per_ff[idx_ff]) begin
               stamp_in[idx_ff] = time_ff;
            end else begin
               run_in[idx_ff] = 1'b0;
            end
            if (alloc_ff[idx_ff]) begin
               mask_in[idx_ff] = 1'b1;
            end
         end
         idx_in = IDX_W'(idx_ff + 1'b1);
      end

      // output register
      if (ovalid_ff && rsp_ready) begin
         ovalid_in = 1'b0;
      end
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         ostat_in  = STATUS_OK;
         ochan_in  = '0;
         olast_in  = 1'b1;
         if (!is_tick) begin
            okind_in = KIND_REPLY;
            ostat_in = rsts_ff;
            ochan_in = rchan_ff;
         end else if (mask_ff == '0) begin
            okind_in = KIND_IDLE_TICK;
         end else begin
            okind_in = KIND_EXPIRE;
            ochan_in = CHAN_W'(low_idx);
            olast_in = mask_rest == '0;
            mask_in  = mask_rest;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= '0;
         alloc_ff  <= '0;
         run_ff    <= '0;
         per_ff    <= '0;
         mask_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         time_ff   <= time_in;
         alloc_ff  <= alloc_in;
         run_ff    <= run_in;
         per_ff    <= per_in;
         mask_ff   <= mask_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      ch_ff    <= ch_in;
      ivl_ff   <= ivl_in;
      rep_ff   <= rep_in;
      stamp_ff <= stamp_in;
      tgt_ff   <= tgt_in;
      idx_ff   <= idx_in;
      rsts_ff  <= rsts_in;
      rchan_ff <= rchan_in;
      okind_ff <= okind_in;
      ostat_ff <= ostat_in;
      ochan_ff <= ochan_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_event_kind  = okind_ff;
   assign rsp_status      = ostat_ff;
   assign rsp_channel_out = ochan_ff;
   assign rsp_last        = olast_ff;

   // Controller only loads a result into a free output slot
   `MCTB_ASSERT_IMPL(a_emit_slot, clock, reset, cmd.emit, slot_free)
   // Each expiry result retires exactly one pending channel
   `MCTB_ASSERT_NEXT(a_mask_retire, clock, reset, cmd.emit && is_tick && (mask_ff != '0), $countones(mask_ff) + 1 == $countones($past(mask_ff)))

endmodule

// ----- design/multi_channel_tick_timer_bank_unit.sv -----
// ---------------------------------------------------------------------------
// multi_channel_tick_timer_bank_unit
// Bank of one-shot/periodic timer channels on a 32-bit tick time base.
//
//   Channel   Dir  Handshake     Payload
//   req_bus   in   valid/ready   action, channel, interval, repeat_req
//   rsp_bus   out  valid/ready   event_kind, status, channel_out, last
//
// A command (create, delete, start, stop) is accepted, decoded and emitted.
// A tick is accepted and decoded, then N = min(CHANNEL_COUNT, 8) channels are
// checked one per cycle by a single subtract-and-compare unit, and R results
// (at least 1) are emitted. Actions 5 to 7 are decoded but give no result.
// Reset clears the time base and all channel flags at once; no sweep.
// Requests are accepted only between items; a result waiting in the output
// register does not block the next request, but a stalled output holds emission.
// ---------------------------------------------------------------------------
module multi_channel_tick_timer_bank_unit
   import mctb_pkg::*;
   #(
   parameter int CHANNEL_COUNT = 8
   )
   (
   input  logic        clock,
   input  logic        reset,
   mctb_req_if.sink    req_bus,
   mctb_rsp_if.source  rsp_bus
   );

   mctb_cmd_type cmd;
   mctb_sts_type sts;
   logic         req_ready;

   assign req_bus.ready = req_ready;

   // Sequencer
   mctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Channel store and result register
   mctb_dpath #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_bus.action),
      .req_channel     (req_bus.channel),
      .req_interval    (req_bus.interval),
      .req_repeat_req  (req_bus.repeat_req),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_event_kind  (rsp_bus.event_kind),
      .rsp_status      (rsp_bus.status),
      .rsp_channel_out (rsp_bus.channel_out),
      .rsp_last        (rsp_bus.last)
   );

endmodule
